### rtl/assert_macros.svh
// Assertion macros used by the RTL top file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// A condition that holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// A condition that implies another one at the next clock edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/gbba_pkg.sv
// ---------------------------------------------------------------------------
// gbba_pkg
// Constants, codes and controller/datapath interface types of the allocator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package gbba_pkg;
    localparam int MAX_GROUPS      = 16;
    localparam int BITS_PER_GROUP  = 8192;
    localparam int WORD_BITS       = 64;
    localparam int WORDS_PER_GROUP = BITS_PER_GROUP / WORD_BITS;
    localparam int MAP_DEPTH       = MAX_GROUPS * WORDS_PER_GROUP;
    localparam int GROUP_W         = $clog2(MAX_GROUPS);
    localparam int WIDX_W          = $clog2(WORDS_PER_GROUP);
    localparam int BIT_W           = $clog2(WORD_BITS);
    localparam int ADDR_W          = GROUP_W + WIDX_W;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_MARK  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    localparam logic [1:0] RES_GRANT   = 2'd0;
    localparam logic [1:0] RES_NOSPACE = 2'd1;
    localparam logic [1:0] RES_RANGE   = 2'd2;
    localparam logic [1:0] RES_OK      = 2'd3;

    localparam logic CFG_GROUP_COUNT = 1'b0;
    localparam logic CFG_BPG         = 1'b1;

    typedef struct packed {
        logic       load;
        logic       clr;
        logic       mod_step;
        logic       div_step;
        logic       grp_next;
        logic       word_next;
        logic       alloc_wr;
        logic       blk_wr;
        logic       res_set;
        logic [1:0] res_sel;
        logic       out_push;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic       clr_last;
        logic       range_bad;
        logic       mod_busy;
        logic       div_busy;
        logic       word_end;
        logic       hit;
        logic       last_group;
        logic       out_busy;
    } t_dp_sts;
endpackage
`default_nettype wire

### rtl/gbba_dp.sv
// ---------------------------------------------------------------------------
// gbba_dp
// Datapath: configuration, bitmap memory, group/word counters, result stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module gbba_dp import gbba_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [13:0] i_cfg_data,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [3:0]  i_pref_group,
    input  wire logic [17:0] i_block_number,
    input  wire logic        i_out_ready,
    output logic             o_out_valid,
    output logic [1:0]       o_status,
    output logic [17:0]      o_allocated_block,
    input  wire t_dp_cmd     i_dp_cmd,
    output t_dp_sts          o_dp_sts
);
    logic [4:0]           r_gc;
    logic [13:0]          r_bpg;
    logic [1:0]           r_cmd;
    logic [GROUP_W-1:0]   r_group;
    logic [WIDX_W:0]      r_word;
    logic [16:0]          r_rem;
    logic [17:0]          r_num;
    logic [4:0]           r_tries;
    logic [ADDR_W-1:0]    r_clr_addr;
    logic [WORD_BITS-1:0] r_rdata;
    logic [1:0]           r_res_status;
    logic [17:0]          r_res_block;
    logic                 r_out_valid;
    logic [1:0]           r_out_status;
    logic [17:0]          r_out_block;
    logic [WORD_BITS-1:0] mem [MAP_DEPTH];

    logic [4:0]           gc;
    logic [13:0]          bpg;
    logic [18:0]          total;
    logic [13:0]          base;
    logic [13:0]          rem_bits;
    logic [WORD_BITS-1:0] avail;
    logic [BIT_W-1:0]     hit_bit;
    logic [ADDR_W-1:0]    addr;
    logic [WORD_BITS-1:0] wdata;
    logic [WORD_BITS-1:0] blk_mask;
    logic                 we;
    logic [17:0]          grant;
    logic [4:0]           grp_inc;

    always_comb begin
        gc  = (r_gc == 5'd0) ? 5'd1 : ((r_gc > 5'(MAX_GROUPS)) ? 5'(MAX_GROUPS) : r_gc);
        bpg = (r_bpg > 14'(BITS_PER_GROUP)) ? 14'(BITS_PER_GROUP) : r_bpg;
        total = 19'(gc) * 19'(bpg);
        base = 14'({r_word, {BIT_W{1'b0}}});
        rem_bits = bpg - base;
        for (int k = 0; k < WORD_BITS; k++) begin
            avail[k] = ~r_rdata[k] & ((rem_bits >= 14'(WORD_BITS)) || (14'(k) < rem_bits));
        end
        hit_bit = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--) begin
            if (avail[k]) begin
                hit_bit = BIT_W'(k);
            end
        end
        grant = 18'(18'(r_group) * 18'(bpg) + 18'(base) + 18'(hit_bit) + 18'd1);
        grp_inc = 5'(r_group) + 5'd1;
        if (i_dp_cmd.clr) begin
            addr = r_clr_addr;
        end else if (r_cmd == CMD_ALLOC) begin
            addr = {r_group, r_word[WIDX_W-1:0]};
        end else begin
            addr = {r_group, r_rem[BIT_W +: WIDX_W]};
        end
        blk_mask = '0;
        blk_mask[r_rem[BIT_W-1:0]] = 1'b1;
        wdata = r_rdata;
        if (i_dp_cmd.clr) begin
            wdata = '0;
        end else if (i_dp_cmd.alloc_wr) begin
            wdata[hit_bit] = 1'b1;
        end else if (r_cmd == CMD_MARK) begin
            wdata = r_rdata | blk_mask;
        end else begin
            wdata = r_rdata & ~blk_mask;
        end
        we = i_dp_cmd.clr | i_dp_cmd.alloc_wr | i_dp_cmd.blk_wr;
    end

    always_comb begin
        o_dp_sts.cmd        = r_cmd;
        o_dp_sts.clr_last   = &r_clr_addr;
        o_dp_sts.range_bad  = (r_num == 18'd0) || (bpg == 14'd0) || (19'(r_num) > total);
        o_dp_sts.mod_busy   = (5'(r_group) >= gc);
        o_dp_sts.div_busy   = (r_rem >= 17'(bpg));
        o_dp_sts.word_end   = (base >= bpg) || r_word[WIDX_W];
        o_dp_sts.hit        = |avail;
        o_dp_sts.last_group = (r_tries + 5'd1 == gc);
        o_dp_sts.out_busy   = r_out_valid && !i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        r_rdata <= mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gc        <= 5'd16;
            r_bpg       <= 14'd8192;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_GROUP_COUNT: r_gc  <= i_cfg_data[4:0];
                    CFG_BPG:         r_bpg <= i_cfg_data;
                    default:         r_gc  <= r_gc;
                endcase
            end
            if (i_dp_cmd.clr) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (i_dp_cmd.out_push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_cmd   <= i_cmd;
            r_num   <= i_block_number;
            r_rem   <= 17'(i_block_number - 18'd1);
            r_group <= (i_cmd == CMD_ALLOC) ? i_pref_group : '0;
            r_word  <= '0;
            r_tries <= '0;
        end
        if (i_dp_cmd.mod_step) begin
            r_group <= r_group - GROUP_W'(gc);
        end
        if (i_dp_cmd.div_step) begin
            r_rem   <= r_rem - 17'(bpg);
            r_group <= r_group + GROUP_W'(1);
        end
        if (i_dp_cmd.grp_next) begin
            r_group <= (grp_inc == gc) ? '0 : GROUP_W'(grp_inc);
            r_tries <= r_tries + 5'd1;
            r_word  <= '0;
        end
        if (i_dp_cmd.word_next) begin
            r_word <= r_word + (WIDX_W+1)'(1);
        end
        if (i_dp_cmd.res_set) begin
            unique case (i_dp_cmd.res_sel)
                RES_GRANT: begin
                    r_res_status <= ST_OK;
                    r_res_block  <= grant;
                end
                RES_NOSPACE: begin
                    r_res_status <= ST_NOSPACE;
                    r_res_block  <= '0;
                end
                RES_RANGE: begin
                    r_res_status <= ST_RANGE;
                    r_res_block  <= '0;
                end
                RES_OK: begin
                    r_res_status <= ST_OK;
                    r_res_block  <= '0;
                end
                default: begin
                    r_res_status <= ST_OK;
                    r_res_block  <= '0;
                end
            endcase
        end
        if (i_dp_cmd.out_push) begin
            r_out_status <= r_res_status;
            r_out_block  <= r_res_block;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_allocated_block = r_out_block;
endmodule
`default_nettype wire

### rtl/gbba_ctrl.sv
// ---------------------------------------------------------------------------
// gbba_ctrl
// Controller: clearing pass, command decode, group/word search sequencing.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module gbba_ctrl import gbba_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_dp_sts i_dp_sts,
    output t_dp_cmd      o_dp_cmd
);
    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECODE = 3'd2;
    localparam logic [2:0] S_MOD    = 3'd3;
    localparam logic [2:0] S_WCHK   = 3'd4;
    localparam logic [2:0] S_WEVAL  = 3'd5;
    localparam logic [2:0] S_DIV    = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_dp_cmd   = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_dp_cmd.clr = 1'b1;
                if (i_dp_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_dp_cmd.load = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_dp_sts.cmd == CMD_ALLOC) begin
                    n_state = S_MOD;
                end else if (i_dp_sts.cmd == CMD_FREE || i_dp_sts.cmd == CMD_MARK) begin
                    if (i_dp_sts.range_bad) begin
                        o_dp_cmd.res_set = 1'b1;
                        o_dp_cmd.res_sel = RES_RANGE;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_DIV;
                    end
                end else begin
                    o_dp_cmd.res_set = 1'b1;
                    o_dp_cmd.res_sel = RES_OK;
                    n_state = S_DONE;
                end
            end
            S_MOD: begin
                // Reduce the preferred group below the group count.
                if (i_dp_sts.mod_busy) begin
                    o_dp_cmd.mod_step = 1'b1;
                end else begin
                    n_state = S_WCHK;
                end
            end
            S_WCHK: begin
                if (i_dp_sts.word_end) begin
                    if (i_dp_sts.last_group) begin
                        o_dp_cmd.res_set = 1'b1;
                        o_dp_cmd.res_sel = RES_NOSPACE;
                        n_state = S_DONE;
                    end else begin
                        o_dp_cmd.grp_next = 1'b1;
                    end
                end else begin
                    n_state = S_WEVAL;
                end
            end
            S_WEVAL: begin
                if (i_dp_sts.hit) begin
                    o_dp_cmd.alloc_wr = 1'b1;
                    o_dp_cmd.res_set  = 1'b1;
                    o_dp_cmd.res_sel  = RES_GRANT;
                    n_state = S_DONE;
                end else begin
                    o_dp_cmd.word_next = 1'b1;
                    n_state = S_WCHK;
                end
            end
            S_DIV: begin
                // Split the block index into group and bit by repeated subtraction.
                if (i_dp_sts.div_busy) begin
                    o_dp_cmd.div_step = 1'b1;
                end else begin
                    n_state = S_DONE;
                    o_dp_cmd.res_set = 1'b1;
                    o_dp_cmd.res_sel = RES_OK;
                end
            end
            S_DONE: begin
                if (i_dp_sts.cmd != CMD_ALLOC && (i_dp_sts.cmd == CMD_FREE
                        || i_dp_sts.cmd == CMD_MARK) && !i_dp_sts.range_bad) begin
                    o_dp_cmd.blk_wr = 1'b1;
                    n_state = S_IDLE;
                    o_dp_cmd.out_push = 1'b1;
                    if (i_dp_sts.out_busy) begin
                        o_dp_cmd.blk_wr   = 1'b0;
                        o_dp_cmd.out_push = 1'b0;
                        n_state = S_DONE;
                    end
                end else if (!i_dp_sts.out_busy) begin
                    o_dp_cmd.out_push = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

### rtl/group_bitmap_block_allocator_top.sv
// ---------------------------------------------------------------------------
// group_bitmap_block_allocator_top
// Block allocator over per-group used/free bitmaps held in one memory.
// ---------------------------------------------------------------------------
// After reset the block runs a clearing pass over all 2048 bitmap words,
// one word a cycle, before it takes its first item; configuration writes
// are taken throughout. One item is worked at a time. A free or mark goes
// through decode, one step of repeated subtraction per group below its
// block's group, and done; a block number out of range or an unused
// command goes from decode straight to done. An allocate brings the
// preferred group below the group count by repeated subtraction, then
// scans bitmap words through the single memory port, checking and
// evaluating each word, and moves on when a group's words run out. A new
// item is taken while a finished result still waits in the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module group_bitmap_block_allocator_top import gbba_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [13:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [3:0]  i_pref_group,
    input  wire logic [17:0] i_block_number,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_status,
    output logic [17:0]      o_allocated_block
);
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    gbba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_dp_sts   (dp_sts),
        .o_dp_cmd   (dp_cmd)
    );

    gbba_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_cmd             (i_cmd),
        .i_pref_group      (i_pref_group),
        .i_block_number    (i_block_number),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_status          (o_status),
        .o_allocated_block (o_allocated_block),
        .i_dp_cmd          (dp_cmd),
        .o_dp_sts          (dp_sts)
    );

    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n,
        i_in_valid && o_in_ready, !o_in_ready, "ready after accept")
    `ASSERT_ALWAYS(a_status_code, i_clk, i_rst_n,
        !o_out_valid || o_status == ST_OK || o_status == ST_NOSPACE || o_status == ST_RANGE,
        "bad status code")
    `ASSERT_ALWAYS(a_grant_only_ok, i_clk, i_rst_n,
        !o_out_valid || o_status == ST_OK || o_allocated_block == 18'd0, "block on failure")
    `ASSERT_ALWAYS(a_push_when_free, i_clk, i_rst_n,
        !dp_cmd.out_push || !dp_sts.out_busy, "result overwritten")
endmodule
`default_nettype wire

### dv/group_bitmap_block_allocator_top_test.sv
// ---------------------------------------------------------------------------
// group_bitmap_block_allocator_top_test
// Self-checking testbench for the group bitmap block allocator.
// ---------------------------------------------------------------------------
// A bit-level copy of the usage bitmap predicts the status and granted block
// of every accepted item. Results are checked in order against the queue of
// predicted grants. Directed tests cover the register extremes, bad block
// numbers, the unused command and full groups. Random phases then mix
// allocates with frees, marks and any command over several geometries, with
// random idling on both channels in all but the last phase.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module group_bitmap_block_allocator_top_test;
    import gbba_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 40000;
    localparam int TOTAL_BLOCKS = MAX_GROUPS * BITS_PER_GROUP;

    typedef struct packed {
        logic [1:0]  status;
        logic [17:0] block;
    } t_grant;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [13:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_cmd = '0;
    logic [3:0]  i_pref_group = '0;
    logic [17:0] i_block_number = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_status;
    logic [17:0] o_allocated_block;

    group_bitmap_block_allocator_top dut (.*);

    // Predictor state.
    bit          used_map [0:TOTAL_BLOCKS-1];
    logic [4:0]  group_count_reg = 5'd16;
    logic [13:0] bpg_reg = 14'd8192;
    t_grant      pending_grants[$];

    bit idle_on = 1'b1;
    int mismatches = 0;
    int items_sent = 0;
    int results_seen = 0;
    int stall_left = 0;
    int quiet_cycles = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int eff_groups();
        if (group_count_reg == 0) return 1;
        if (group_count_reg > MAX_GROUPS) return MAX_GROUPS;
        return group_count_reg;
    endfunction

    function automatic int eff_bpg();
        if (bpg_reg > BITS_PER_GROUP) return BITS_PER_GROUP;
        return bpg_reg;
    endfunction

    function automatic t_grant predict_grant(logic [1:0] cmd, logic [3:0] pref,
                                             logic [17:0] num);
        t_grant r;
        int gc;
        int bpg;
        int g;
        int idx;
        bit found;
        gc = eff_groups();
        bpg = eff_bpg();
        r.status = ST_OK;
        r.block = '0;
        found = 1'b0;
        if (cmd == CMD_ALLOC) begin
            r.status = ST_NOSPACE;
            for (int i = 0; i < gc && !found; i++) begin
                g = (pref + i) % gc;
                for (int b = 0; b < bpg && !found; b++) begin
                    if (!used_map[g * BITS_PER_GROUP + b]) begin
                        used_map[g * BITS_PER_GROUP + b] = 1'b1;
                        r.block = 18'(g * bpg + b + 1);
                        r.status = ST_OK;
                        found = 1'b1;
                    end
                end
            end
        end else if (cmd == CMD_FREE || cmd == CMD_MARK) begin
            if (num == 0 || bpg == 0 || int'(num) > gc * bpg) begin
                r.status = ST_RANGE;
            end else begin
                idx = int'(num) - 1;
                used_map[(idx / bpg) * BITS_PER_GROUP + idx % bpg] = (cmd == CMD_MARK);
            end
        end
        return r;
    endfunction

    // Called at a rising edge; returns at the edge where the item is taken.
    task automatic send_item(logic [1:0] cmd, logic [3:0] pref, logic [17:0] num);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_pref_group <= pref;
        i_block_number <= num;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_grants.push_back(predict_grant(cmd, pref, num));
        items_sent++;
    endtask

    // Waits for every result, so the block is idle for a register write.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_grants.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [13:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_GROUP_COUNT) group_count_reg = data[4:0];
        else bpg_reg = data;
    endtask

    task automatic test_reset_geometry();
        send_item(CMD_ALLOC, 4'd0, 18'd0);
        send_item(CMD_ALLOC, 4'd15, 18'h3FFFF);
        send_item(CMD_ALLOC, 4'd15, 18'd0);
        send_item(CMD_MARK, 4'd0, 18'd131072);
        send_item(CMD_MARK, 4'd9, 18'd131072);
        send_item(CMD_FREE, 4'd0, 18'd131072);
        send_item(CMD_FREE, 4'd0, 18'd131072);
        send_item(CMD_FREE, 4'd0, 18'd0);
        send_item(CMD_MARK, 4'd0, 18'd131073);
        send_item(CMD_FREE, 4'hF, 18'h3FFFF);
        send_item(CMD_UNUSED, 4'hF, 18'h3FFFF);
        send_item(CMD_FREE, 4'd0, 18'd1);
        send_item(CMD_ALLOC, 4'd0, 18'd0);
        drain();
    endtask

    task automatic test_small_and_full();
        // A group count of zero acts as one group; a tiny group fills fast.
        write_reg(CFG_GROUP_COUNT, 14'd0);
        write_reg(CFG_BPG, 14'd8);
        for (int i = 0; i < 9; i++) send_item(CMD_ALLOC, 4'(i + 7), 18'd0);
        send_item(CMD_FREE, 4'd0, 18'd5);
        send_item(CMD_ALLOC, 4'd3, 18'd0);
        send_item(CMD_MARK, 4'd0, 18'd9);
        drain();
        // Oversized values clamp; bits set earlier stay set.
        write_reg(CFG_GROUP_COUNT, 14'd31);
        write_reg(CFG_BPG, 14'h3FFF);
        send_item(CMD_ALLOC, 4'd0, 18'd0);
        send_item(CMD_ALLOC, 4'd5, 18'd0);
        drain();
        write_reg(CFG_BPG, 14'd0);
        send_item(CMD_ALLOC, 4'd2, 18'd0);
        send_item(CMD_FREE, 4'd0, 18'd1);
        send_item(CMD_MARK, 4'd0, 18'd1);
        drain();
        // Odd size and a preferred group beyond the count.
        write_reg(CFG_GROUP_COUNT, 14'd3);
        write_reg(CFG_BPG, 14'd13);
        send_item(CMD_ALLOC, 4'd14, 18'd0);
        send_item(CMD_MARK, 4'd0, 18'd39);
        send_item(CMD_MARK, 4'd0, 18'd40);
        drain();
    endtask

    task automatic test_random_phase(int count);
        int gc;
        int bpg;
        int top;
        int pick;
        gc = $urandom_range(1, 16);
        bpg = ($urandom_range(0, 3) == 0) ? 8 : 8 * $urandom_range(1, 40);
        write_reg(CFG_GROUP_COUNT, 14'(gc));
        write_reg(CFG_BPG, 14'(bpg));
        top = gc * bpg;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                send_item(CMD_ALLOC, 4'($urandom), 18'($urandom));
            else if (pick < 78)
                send_item(CMD_FREE, 4'($urandom), 18'($urandom_range(1, top)));
            else if (pick < 92)
                send_item(CMD_MARK, 4'($urandom), 18'($urandom_range(1, top)));
            else
                send_item(2'($urandom), 4'($urandom), 18'($urandom));
        end
        drain();
    endtask

    // Result checking, output stalls and the watchdog.
    always @(posedge i_clk) begin
        t_grant want;
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else if (i_rst_n)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > QUIET_LIMIT) begin
            $display("Timeout with %0d results outstanding", pending_grants.size());
            $display("Verification failed");
            $finish;
        end
        if (o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending_grants.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result at %0t: status %0d block %0d, expected none",
                             $realtime, o_status, o_allocated_block);
            end else begin
                want = pending_grants.pop_front();
                if (o_status !== want.status || o_allocated_block !== want.block) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: status %0d block %0d, expected %0d block %0d",
                                 o_status, o_allocated_block, want.status, want.block);
                end
            end
        end
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 16);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_geometry();
        test_small_and_full();
        for (int p = 0; p < 5; p++) test_random_phase(110);
        idle_on = 1'b0;
        test_random_phase(80);
        repeat (50) @(posedge i_clk);
        $display("Sent %0d items and checked %0d results over several group geometries,",
                 items_sent, results_seen);
        $display("including clamped, zero and full-group settings.");
        if (mismatches == 0 && pending_grants.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     pending_grants.size());
            $display("Verification failed");
        end
        $finish;
    end
endmodule
